/* design/aegis_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AEGIS-128 shared definitions
// Operation and result codes, constants, controller commands and the AES round.
// ----------------------------------------------------------------------------
package aegis_pkg;

  localparam int CountWidthDefault = 32;

  // Operation codes
  localparam logic [1:0] OP_INIT     = 2'd0;
  localparam logic [1:0] OP_ENCRYPT  = 2'd1;
  localparam logic [1:0] OP_FINALIZE = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_INIT  = 2'd0;
  localparam logic [1:0] RES_CIPHER = 2'd1;
  localparam logic [1:0] RES_TAG   = 2'd2;
  localparam logic [1:0] RES_ERROR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  localparam logic [127:0] FIB_C0 = 128'h000101020305080d1522375990e97962;
  localparam logic [127:0] FIB_C1 = 128'hdb3d18556dc22ff12011314273b528dd;

  // Datapath commands from the controller
  typedef struct packed {
    logic load_init;   // load the initial state from key and nonce
    logic step_key;    // update with the key
    logic step_kiv;    // update with key xor nonce
    logic step_text;   // encrypt: emit ciphertext and update with plaintext
    logic latch_len;   // capture the length word for finalize
    logic step_len;    // update with the length word
    logic emit_tag;    // capture the tag
    logic emit_init;   // init done result
    logic emit_err;    // error result
  } aegis_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits at bits [127-8i -: 8].
  function automatic logic [127:0] aes_round(input logic [127:0] a, input logic [127:0] w);
    logic [7:0] t [16];
    logic [7:0] b0, b1, b2, b3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(a[127 - 8*(r + 4*((c + r) & 3)) -: 8]);
      end
    end
    o = '0;
    for (int c = 0; c < 4; c++) begin
      b0 = t[4*c]; b1 = t[4*c+1]; b2 = t[4*c+2]; b3 = t[4*c+3];
      al = b0 ^ b1 ^ b2 ^ b3;
      o[127 - 32*c -: 8]      = b0 ^ al ^ xtime(b0 ^ b1);
      o[127 - 32*c - 8 -: 8]  = b1 ^ al ^ xtime(b1 ^ b2);
      o[127 - 32*c - 16 -: 8] = b2 ^ al ^ xtime(b2 ^ b3);
      o[127 - 32*c - 24 -: 8] = b3 ^ al ^ xtime(b3 ^ b0);
    end
    return o ^ w;
  endfunction

endpackage
`default_nettype wire

/* design/aegis_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AEGIS-128 datapath
// State words, key registers, block counter and one state update per cycle while the controller commands it.
// ----------------------------------------------------------------------------
module aegis_datapath #(
  parameter int COUNT_WIDTH = aegis_pkg::CountWidthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [63:0]       cfg_wdata,
  input  wire logic [127:0]      text,
  input  wire aegis_pkg::aegis_cmd_t cmd,
  output logic [1:0]             res_kind,
  output logic [127:0]           res_data
);
  import aegis_pkg::*;

  logic [127:0] s_r [5];
  logic [127:0] s_nxt [5];
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [127:0] len_r, msg, key, kiv, lenw;
  logic [63:0]  bits;

  assign key = {key_hi_r, key_lo_r};
  assign kiv = key ^ {iv_hi_r, iv_lo_r};

  // Bit length as a little-endian word in bytes 8 to 15.
  always_comb begin
    bits = 64'(cnt_r) << 7;
    lenw = '0;
    for (int i = 0; i < 8; i++) begin
      lenw[63 - 8*i -: 8] = bits[8*i +: 8];
    end
  end

  // Message word select and the five parallel rounds.
  always_comb begin
    msg = len_r;
    if (cmd.step_key) msg = key;
    else if (cmd.step_kiv) msg = kiv;
    else if (cmd.step_text) msg = text;
    s_nxt[0] = aes_round(s_r[4], s_r[0] ^ msg);
    s_nxt[1] = aes_round(s_r[0], s_r[1]);
    s_nxt[2] = aes_round(s_r[1], s_r[2]);
    s_nxt[3] = aes_round(s_r[2], s_r[3]);
    s_nxt[4] = aes_round(s_r[3], s_r[4]);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0; iv_hi_r <= '0; iv_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_hi_r <= cfg_wdata;
        REG_KEY_LOW:  key_lo_r <= cfg_wdata;
        REG_IV_HIGH:  iv_hi_r <= cfg_wdata;
        REG_IV_LOW:   iv_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) s_r[i] <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.load_init) begin
        s_r[0] <= kiv;
        s_r[1] <= FIB_C1;
        s_r[2] <= FIB_C0;
        s_r[3] <= key ^ FIB_C0;
        s_r[4] <= key ^ FIB_C1;
        cnt_r  <= '0;
      end else if (cmd.step_key || cmd.step_kiv || cmd.step_text || cmd.step_len) begin
        for (int i = 0; i < 5; i++) s_r[i] <= s_nxt[i];
      end
      if (cmd.step_text) cnt_r <= cnt_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) len_r <= s_r[3] ^ lenw;
    if (cmd.step_text) begin
      res_kind <= RES_CIPHER;
      res_data <= text ^ s_r[1] ^ s_r[4] ^ (s_r[2] & s_r[3]);
    end else if (cmd.emit_tag) begin
      res_kind <= RES_TAG;
      res_data <= s_r[0] ^ s_r[1] ^ s_r[2] ^ s_r[3] ^ s_r[4];
    end else if (cmd.emit_init) begin
      res_kind <= RES_INIT;
      res_data <= '0;
    end else if (cmd.emit_err) begin
      res_kind <= RES_ERROR;
      res_data <= '0;
    end
  end

endmodule
`default_nettype wire

/* design/aegis_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AEGIS-128 controller
// Sequences init, encrypt and finalize and runs the output handshake.
// ----------------------------------------------------------------------------
module aegis_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output aegis_pkg::aegis_cmd_t cmd
);
  import aegis_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       rdy_r, rdy_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  // Accept in idle when no result is pending or it leaves this cycle.
  assign in_ready  = (state_r == ST_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign take      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rdy_nxt   = rdy_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_op == OP_INIT) begin
            cmd.load_init = 1'b1;
            cnt_nxt = '0;
            state_nxt = ST_INIT;
          end else if (in_op == OP_ENCRYPT && rdy_r) begin
            cmd.step_text = 1'b1;
            ov_nxt = 1'b1;
          end else if (in_op == OP_FINALIZE && rdy_r) begin
            cmd.latch_len = 1'b1;
            cnt_nxt = '0;
            state_nxt = ST_FIN;
          end else begin
            cmd.emit_err = 1'b1;
            ov_nxt = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.step_key = !cnt_r[0];
        cmd.step_kiv = cnt_r[0];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd9) begin
          state_nxt = ST_OUT;
          rdy_nxt = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.step_len = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd6) begin
          state_nxt = ST_OUT;
          rdy_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        // Wait here until the previous result has left.
        if (!ov_r || out_ready) begin
          cmd.emit_init = rdy_r;
          cmd.emit_tag  = !rdy_r;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rdy_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdy_r   <= rdy_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // A pending result is not dropped while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Only one result source is loaded at a time.
  a_onecmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.step_text, cmd.emit_tag, cmd.emit_init, cmd.emit_err}))
    else $error("result sources collide");
  // No item is taken while a sequence runs.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT || state_r == ST_FIN) |-> !in_ready)
    else $error("accept while busy");

endmodule
`default_nettype wire

/* design/aegis128_encrypt_core_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// AEGIS-128 encrypt core
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// Timing: an encrypt beat's ciphertext is registered at the accepting edge,
// and the next input beat is taken only in an idle cycle where no result
// waits or the waiting one leaves at that edge. Initialize runs load, ten
// state updates and result load, finalize runs length capture, seven updates
// and tag load, on the single five-round update unit; a result load waits for
// a stalled earlier result. Encrypt or finalize before initialize or after
// finalize, or op code 3, gives an error beat with zero data. Key and nonce
// are used while initialize runs and must not change until it is done.
module aegis128_encrypt_core_unit #(
  parameter int COUNT_WIDTH = aegis_pkg::CountWidthDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,   // operation[1:0], text_high[65:2], text_low[129:66]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata   // result_kind[1:0], out_high[65:2], out_low[129:66]
);
  import aegis_pkg::*;

  aegis_cmd_t   cmd;
  logic [1:0]   res_kind;
  logic [127:0] res_data;

  aegis_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_op(in_tdata[1:0]), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd)
  );

  aegis_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .text({in_tdata[65:2], in_tdata[129:66]}),
    .cmd(cmd), .res_kind(res_kind), .res_data(res_data)
  );

  assign out_tdata = {6'd0, res_data[63:0], res_data[127:64], res_kind};

endmodule
`default_nettype wire

/* bench/aegis_checker.sv */
// ----------------------------------------------------------------------------
// AEGIS-128 result checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the cipher state, and compares every output beat with the predicted one.
// ----------------------------------------------------------------------------
module aegis_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           cipher_seen,
  output int           tag_seen,
  output int           error_seen
);
  import aegis_pkg::*;

  typedef struct packed {
    logic [1:0]   kind;
    logic [127:0] data;
  } aegis_result_t;

  logic [127:0] key_word, iv_word;
  logic [127:0] st [5];
  logic [COUNT_WIDTH-1:0] blocks_done;
  logic session_open;
  aegis_result_t expected_results [$];

  // One AES round: MixColumns(ShiftRows(SubBytes(a))) xor w, byte 0 at the top.
  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] a, input logic [127:0] w);
    logic [7:0] s [16];
    logic [7:0] b0, b1, b2, b3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[r + 4*c] = sbox(a[127 - 8*(r + 4*((c + r) & 3)) -: 8]);
    for (int c = 0; c < 4; c++) begin
      b0 = s[4*c]; b1 = s[4*c+1]; b2 = s[4*c+2]; b3 = s[4*c+3];
      al = b0 ^ b1 ^ b2 ^ b3;
      o[127 - 32*c -: 8]      = b0 ^ al ^ gmul2(b0 ^ b1);
      o[127 - 32*c - 8 -: 8]  = b1 ^ al ^ gmul2(b1 ^ b2);
      o[127 - 32*c - 16 -: 8] = b2 ^ al ^ gmul2(b2 ^ b3);
      o[127 - 32*c - 24 -: 8] = b3 ^ al ^ gmul2(b3 ^ b0);
    end
    return o ^ w;
  endfunction

  task automatic update_state(input logic [127:0] m);
    logic [127:0] n [5];
    n[0] = round_fn(st[4], st[0] ^ m);
    n[1] = round_fn(st[0], st[1]);
    n[2] = round_fn(st[1], st[2]);
    n[3] = round_fn(st[2], st[3]);
    n[4] = round_fn(st[3], st[4]);
    st = n;
  endtask

  // Work out the single result of one accepted input beat.
  task automatic predict_beat(input logic [135:0] beat);
    logic [1:0] op;
    logic [127:0] p, c, lenw;
    logic [63:0] bits;
    aegis_result_t r;
    op = beat[1:0];
    p = {beat[65:2], beat[129:66]};
    r.kind = RES_ERROR;
    r.data = '0;
    if (op == OP_INIT) begin
      st[0] = key_word ^ iv_word;
      st[1] = FIB_C1;
      st[2] = FIB_C0;
      st[3] = key_word ^ FIB_C0;
      st[4] = key_word ^ FIB_C1;
      for (int j = 0; j < 10; j++)
        update_state((j & 1) ? (key_word ^ iv_word) : key_word);
      blocks_done = '0;
      session_open = 1'b1;
      r.kind = RES_INIT;
    end else if (op == OP_ENCRYPT && session_open) begin
      c = p ^ st[1] ^ st[4] ^ (st[2] & st[3]);
      update_state(p);
      blocks_done = blocks_done + 1'b1;
      r.kind = RES_CIPHER;
      r.data = c;
    end else if (op == OP_FINALIZE && session_open) begin
      bits = 64'(blocks_done) << 7;
      lenw = '0;
      // Length bytes 8..15 are little endian.
      for (int i = 0; i < 8; i++) lenw[63 - 8*i -: 8] = bits[8*i +: 8];
      lenw = st[3] ^ lenw;
      for (int j = 0; j < 7; j++) update_state(lenw);
      r.kind = RES_TAG;
      r.data = st[0] ^ st[1] ^ st[2] ^ st[3] ^ st[4];
      session_open = 1'b0;
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    fail_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    aegis_result_t w;
    if (!rst_n) begin
      key_word = '0; iv_word = '0;
      for (int i = 0; i < 5; i++) st[i] = '0;
      blocks_done = '0;
      session_open = 1'b0;
      fail_count = 0; cipher_seen = 0; tag_seen = 0; error_seen = 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata[129:2], '0);
        end else begin
          w = expected_results.pop_front();
          if (out_tdata[1:0] != w.kind)
            report_mismatch("result_kind", 128'(out_tdata[1:0]), 128'(w.kind));
          if (out_tdata[65:2] != w.data[127:64])
            report_mismatch("out_high", 128'(out_tdata[65:2]), 128'(w.data[127:64]));
          if (out_tdata[129:66] != w.data[63:0])
            report_mismatch("out_low", 128'(out_tdata[129:66]), 128'(w.data[63:0]));
          if (w.kind == RES_CIPHER) cipher_seen++;
          if (w.kind == RES_TAG) tag_seen++;
          if (w.kind == RES_ERROR) error_seen++;
        end
      end
      // A beat accepted at this edge still sees the registers from before it.
      if (in_tvalid && in_tready) predict_beat(in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: key_word[127:64] = cfg_wdata;
          REG_KEY_LOW:  key_word[63:0]   = cfg_wdata;
          REG_IV_HIGH:  iv_word[127:64]  = cfg_wdata;
          REG_IV_LOW:   iv_word[63:0]    = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_count = expected_results.size();
  end
endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// AEGIS-128 encrypt core testbench
// Drives directed and random sessions with random gaps and output stalls, and
// rewrites key and nonce between phases; the checker judges every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import aegis_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;
  int fail_count, pending_count, cipher_seen, tag_seen, error_seen;
  int beats_sent = 0;
  bit hold_output = 1'b0;
  bit stim_done = 1'b0;

  always #2 clk = ~clk;

  aegis128_encrypt_core_unit u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  aegis_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending_count, .cipher_seen, .tag_seen, .error_seen
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Send one beat, waiting for the handshake, then an optional gap.
  task automatic send_beat(input logic [1:0] op, input logic [63:0] hi, input logic [63:0] lo,
                           input bit no_gap);
    int g;
    in_tdata <= {6'd0, lo, hi, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_keys(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] vh, input logic [63:0] vl);
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_IV_HIGH, vh);
    write_reg(REG_IV_LOW, vl);
  endtask

  // Output side: random stalls; a long hold-off when asked.
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_output = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int len;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors before init, unused op code, zero key session.
    send_beat(OP_ENCRYPT, '1, '1, 0);
    send_beat(OP_FINALIZE, '0, '0, 0);
    send_beat(2'd3, '1, '0, 0);
    send_beat(OP_INIT, '0, '0, 0);
    send_beat(OP_ENCRYPT, '0, '0, 0);
    send_beat(OP_ENCRYPT, '1, '1, 1);
    send_beat(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1);
    send_beat(2'd3, '1, '1, 0);
    send_beat(OP_FINALIZE, '0, '0, 0);
    send_beat(OP_ENCRYPT, '1, '1, 0);
    send_beat(OP_FINALIZE, '1, '1, 0);
    go_idle();

    // All-ones key and nonce, then a key change after init.
    load_keys('1, '1, '1, '1);
    send_beat(OP_INIT, '0, '0, 0);
    send_beat(OP_FINALIZE, '0, '0, 0);
    send_beat(OP_INIT, '0, '0, 0);
    go_idle();
    write_reg(REG_KEY_HIGH, 64'h8000000000000001);
    send_beat(OP_ENCRYPT, 64'h8000000000000000, 64'h1, 0);
    send_beat(OP_INIT, '0, '0, 0);
    send_beat(OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0);
    send_beat(OP_FINALIZE, '0, '0, 0);
    go_idle();

    // Random sessions; the receiver holds off mid-run.
    while (beats_sent < 770) begin
      if ($urandom_range(0, 3) == 0) begin
        go_idle();
        load_keys(rand64(), rand64(), rand64(), rand64());
      end
      if (beats_sent > 300 && beats_sent < 330) hold_output = 1'b1;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        send_beat(2'($urandom_range(0, 3)), rand64(), rand64(), 0);
      end else begin
        send_beat(OP_INIT, rand64(), rand64(), 0);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          send_beat(($urandom_range(0, 30) == 0) ? 2'd3 : OP_ENCRYPT, rand64(), rand64(),
                    $urandom_range(0, 2) == 0);
        if (r != 1) send_beat(OP_FINALIZE, rand64(), rand64(), 0);
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d input beats: %0d ciphertext, %0d tags, %0d error results.",
             beats_sent, cipher_seen, tag_seen, error_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
design/aegis_pkg.sv
design/aegis_datapath.sv
design/aegis_ctrl.sv
design/aegis128_encrypt_core_unit.sv
bench/aegis_checker.sv
bench/testbench.sv
